// ===== src/rv32_instruction_encoder_defines.svh =====
// assertion macros shared by the checker
`ifndef RV32_INSTRUCTION_ENCODER_DEFINES_SVH
`define RV32_INSTRUCTION_ENCODER_DEFINES_SVH

// checked only while out of reset
`define RV32E_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define RV32E_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/rv32e_pkg.sv =====
package rv32e_pkg;

    typedef logic [5:0] action_t;

    localparam action_t ACT_ADD    = 6'd0;
    localparam action_t ACT_SUB    = 6'd1;
    localparam action_t ACT_SLL    = 6'd2;
    localparam action_t ACT_SLT    = 6'd3;
    localparam action_t ACT_SLTU   = 6'd4;
    localparam action_t ACT_XOR    = 6'd5;
    localparam action_t ACT_SRL    = 6'd6;
    localparam action_t ACT_SRA    = 6'd7;
    localparam action_t ACT_OR     = 6'd8;
    localparam action_t ACT_AND    = 6'd9;
    localparam action_t ACT_JALR   = 6'd10;
    localparam action_t ACT_ECALL  = 6'd11;
    localparam action_t ACT_ADDI   = 6'd12;
    localparam action_t ACT_SLTI   = 6'd13;
    localparam action_t ACT_SLTIU  = 6'd14;
    localparam action_t ACT_SLLI   = 6'd15;
    localparam action_t ACT_SRLI   = 6'd16;
    localparam action_t ACT_SRAI   = 6'd17;
    localparam action_t ACT_XORI   = 6'd18;
    localparam action_t ACT_ORI    = 6'd19;
    localparam action_t ACT_ANDI   = 6'd20;
    localparam action_t ACT_LB     = 6'd21;
    localparam action_t ACT_LH     = 6'd22;
    localparam action_t ACT_LW     = 6'd23;
    localparam action_t ACT_LBU    = 6'd24;
    localparam action_t ACT_LHU    = 6'd25;
    localparam action_t ACT_SB     = 6'd26;
    localparam action_t ACT_SH     = 6'd27;
    localparam action_t ACT_SW     = 6'd28;
    localparam action_t ACT_BEQ    = 6'd29;
    localparam action_t ACT_BNE    = 6'd30;
    localparam action_t ACT_BLT    = 6'd31;
    localparam action_t ACT_BGE    = 6'd32;
    localparam action_t ACT_BLTU   = 6'd33;
    localparam action_t ACT_BGEU   = 6'd34;
    localparam action_t ACT_LUI    = 6'd35;
    localparam action_t ACT_AUIPC  = 6'd36;
    localparam action_t ACT_JAL    = 6'd37;
    localparam action_t ACT_FLW    = 6'd38;
    localparam action_t ACT_FSW    = 6'd39;
    localparam action_t ACT_FADD_S = 6'd40;
    localparam action_t ACT_NOP    = 6'd41;
    localparam action_t ACT_HALT   = 6'd42;
    localparam action_t ACT_DATA   = 6'd43;

    localparam logic [6:0] OPC_R      = 7'b0110011;
    localparam logic [6:0] OPC_I      = 7'b0010011;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_FLW    = 7'b0000111;
    localparam logic [6:0] OPC_FSW    = 7'b0100111;
    localparam logic [6:0] OPC_FOP    = 7'b1010011;

    localparam logic [6:0]  FUNCT7_ALT   = 7'b0100000;
    localparam logic [2:0]  FUNCT3_WORD  = 3'd2;
    localparam logic [2:0]  FUNCT3_FADD  = 3'd7;
    localparam logic [31:0] WORD_HALT    = 32'hFFFF_FFFF;
    localparam logic [31:0] WORD_STEP    = 32'd4;

    typedef struct packed {
        action_t     action;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
        logic [31:0] immediate;
        logic [31:0] label_address;
        logic        use_label;
        logic [15:0] byte_count;
    } item_t;

    typedef struct packed {
        logic        emit;
        logic [31:0] word;
        logic [31:0] lc_next;
    } enc_t;

    function automatic logic [2:0] alu_funct3(action_t act);
        logic [2:0] f;
        case (act)
            ACT_ADD, ACT_SUB: f = 3'd0;
            ACT_SLL:          f = 3'd1;
            ACT_SLT:          f = 3'd2;
            ACT_SLTU:         f = 3'd3;
            ACT_XOR:          f = 3'd4;
            ACT_SRL, ACT_SRA: f = 3'd5;
            ACT_OR:           f = 3'd6;
            ACT_AND:          f = 3'd7;
            default:          f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] imm_funct3(action_t act);
        logic [2:0] f;
        case (act)
            ACT_JALR:            f = 3'd0;
            ACT_ECALL:           f = 3'd7;
            ACT_ADDI:            f = 3'd0;
            ACT_SLTI:            f = 3'd2;
            ACT_SLTIU:           f = 3'd3;
            ACT_SLLI:            f = 3'd1;
            ACT_SRLI, ACT_SRAI:  f = 3'd5;
            ACT_XORI:            f = 3'd4;
            ACT_ORI:             f = 3'd6;
            ACT_ANDI:            f = 3'd7;
            default:             f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] load_funct3(action_t act);
        logic [2:0] f;
        case (act)
            ACT_LB:  f = 3'd0;
            ACT_LH:  f = 3'd1;
            ACT_LW:  f = 3'd2;
            ACT_LBU: f = 3'd4;
            ACT_LHU: f = 3'd5;
            default: f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] store_funct3(action_t act);
        logic [2:0] f;
        case (act)
            ACT_SB:  f = 3'd0;
            ACT_SH:  f = 3'd1;
            ACT_SW:  f = 3'd2;
            default: f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] branch_funct3(action_t act);
        logic [2:0] f;
        case (act)
            ACT_BEQ:  f = 3'd0;
            ACT_BNE:  f = 3'd1;
            ACT_BLT:  f = 3'd4;
            ACT_BGE:  f = 3'd5;
            ACT_BLTU: f = 3'd6;
            ACT_BGEU: f = 3'd7;
            default:  f = 3'd0;
        endcase
        return f;
    endfunction

endpackage

// ===== src/rv32e_encode.sv =====
module rv32e_encode
    import rv32e_pkg::*;
(
    input  item_t       item,
    input  logic [31:0] lc,
    output enc_t        enc
);

    logic [31:0] operand;
    logic [31:0] rel;
    logic [31:0] jal_off;
    logic [11:0] i_imm;
    logic [19:0] j_field;

    assign operand = item.use_label ? item.label_address : item.immediate;
    assign rel     = item.label_address - lc;
    assign jal_off = item.use_label ? rel : item.immediate;
    assign j_field = {jal_off[20], jal_off[10:1], jal_off[11], jal_off[19:12]};

    // shift forms keep only shamt, srai sets the alternate bit
    always_comb
    begin
        if (item.action == ACT_SLLI || item.action == ACT_SRLI || item.action == ACT_SRAI)
        begin
            i_imm = {1'b0, (item.action == ACT_SRAI), 5'b0, operand[4:0]};
        end
        else
        begin
            i_imm = operand[11:0];
        end
    end

    always_comb
    begin
        enc.emit    = 1'b1;
        enc.word    = '0;
        enc.lc_next = lc + WORD_STEP;
        case (item.action) inside
            [ACT_ADD:ACT_AND]:
            begin
                enc.word = {((item.action == ACT_SUB || item.action == ACT_SRA) ?
                             FUNCT7_ALT : 7'b0),
                            item.src2_reg, item.src1_reg, alu_funct3(item.action),
                            item.dest_reg, OPC_R};
            end
            [ACT_JALR:ACT_ANDI]:
            begin
                enc.word = {i_imm, item.src1_reg, imm_funct3(item.action), item.dest_reg,
                            ((item.action == ACT_JALR || item.action == ACT_ECALL) ?
                             OPC_JALR : OPC_I)};
            end
            [ACT_LB:ACT_LHU]:
            begin
                enc.word = {item.immediate[11:0], item.src1_reg, load_funct3(item.action),
                            item.dest_reg, OPC_LOAD};
            end
            [ACT_SB:ACT_SW]:
            begin
                enc.word = {item.immediate[11:5], item.dest_reg, item.src1_reg,
                            store_funct3(item.action), item.immediate[4:0], OPC_STORE};
            end
            [ACT_BEQ:ACT_BGEU]:
            begin
                enc.word = {rel[12], rel[10:5], item.src2_reg, item.src1_reg,
                            branch_funct3(item.action), rel[4:1], rel[11], OPC_BRANCH};
            end
            ACT_LUI:
            begin
                enc.word = {item.immediate[19:0], item.dest_reg, OPC_LUI};
            end
            ACT_AUIPC:
            begin
                enc.word = {item.immediate[19:0], item.dest_reg, OPC_AUIPC};
            end
            ACT_JAL:
            begin
                enc.word = {j_field, item.dest_reg, OPC_JAL};
            end
            ACT_FLW:
            begin
                enc.word = {item.immediate[11:0], item.src1_reg, FUNCT3_WORD,
                            item.dest_reg, OPC_FLW};
            end
            ACT_FSW:
            begin
                enc.word = {item.immediate[11:5], item.dest_reg, item.src1_reg,
                            FUNCT3_WORD, item.immediate[4:0], OPC_FSW};
            end
            ACT_FADD_S:
            begin
                enc.word = {7'b0, item.src2_reg, item.src1_reg, FUNCT3_FADD,
                            item.dest_reg, OPC_FOP};
            end
            ACT_NOP:
            begin
                enc.word = '0;
            end
            ACT_HALT:
            begin
                enc.word = WORD_HALT;
            end
            ACT_DATA:
            begin
                enc.emit    = 1'b0;
                enc.lc_next = lc + {16'b0, item.byte_count};
            end
            default:
            begin
                enc.emit    = 1'b0;
                enc.lc_next = lc;
            end
        endcase
    end

endmodule

// ===== src/rv32_instruction_encoder.sv =====
// channel   handshake            payload
// input     in_valid/in_ready    action dest_reg src1_reg src2_reg immediate
//                                label_address use_label byte_count
// output    out_valid/out_ready  machine_word word_address
//
// one word per cycle on each side unless stalled; via item_reg, then output regs
// the location counter updates as an item leaves the input register
// data skips and unknown actions leave the pipe without a word
// reset clears the location counter and both valid flags
// a stalled output holds its word and the input register holds one more
module rv32_instruction_encoder
    import rv32e_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [5:0]         action,
    input  logic [4:0]         dest_reg,
    input  logic [4:0]         src1_reg,
    input  logic [4:0]         src2_reg,
    input  logic signed [31:0] immediate,
    input  logic [31:0]        label_address,
    input  logic               use_label,
    input  logic [15:0]        byte_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        machine_word,
    output logic [31:0]        word_address
);

    item_t       item_reg;
    logic        item_valid_reg;
    logic [31:0] lc_reg;
    logic        out_valid_reg;
    logic [31:0] machine_word_reg;
    logic [31:0] word_address_reg;
    enc_t        enc;
    logic        out_free;
    logic        advance;

    rv32e_encode u_encode
    (
        .item (item_reg),
        .lc   (lc_reg),
        .enc  (enc)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            lc_reg         <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance && enc.emit;
            end
            if (advance)
            begin
                lc_reg <= enc.lc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.action        <= action;
            item_reg.dest_reg      <= dest_reg;
            item_reg.src1_reg      <= src1_reg;
            item_reg.src2_reg      <= src2_reg;
            item_reg.immediate     <= immediate;
            item_reg.label_address <= label_address;
            item_reg.use_label     <= use_label;
            item_reg.byte_count    <= byte_count;
        end
        if (advance)
        begin
            machine_word_reg <= enc.word;
            word_address_reg <= lc_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign machine_word = machine_word_reg;
    assign word_address = word_address_reg;

endmodule

// ===== src/rv32e_checker.sv =====
`include "rv32_instruction_encoder_defines.svh"

module rv32e_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] machine_word,
    input logic [31:0] word_address
);

    // an empty output stage always frees the input side
    `RV32E_ASSERT_ALWAYS(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

    `RV32E_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |-> !out_valid, "word shown during reset")

    `RV32E_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "word dropped while stalled")

    `RV32E_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(machine_word) && $stable(word_address), "stalled word changed")

endmodule

bind rv32_instruction_encoder rv32e_checker u_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .machine_word (machine_word),
    .word_address (word_address)
);

// ===== bench/rv32_instruction_encoder_tb.sv =====
`timescale 1ns / 100ps

module rv32_instruction_encoder_tb;
    import rv32e_pkg::*;

    localparam action_t ACT_UNDEF_LAST = 6'd63;
    localparam int      RANDOM_ITEMS   = 1000;
    localparam int      IDLE_LIMIT     = 2000;
    localparam int      HOLD_OFF       = 400;
    localparam int      HOLD_AT_WORD   = 150;
    localparam int      DRAIN_CYCLES   = 8;
    localparam int      REPORT_MAX     = 10;

    typedef struct {
        logic [31:0] word;
        logic [31:0] addr;
    } placed_word_t;

    class encoder_shadow;
        logic [31:0]  lc;
        placed_word_t placed_words[$];
        int           mismatches;
        int           words_checked;

        function new();
            lc = '0;
            mismatches = 0;
            words_checked = 0;
        endfunction

        // predicts the word for one accepted statement and advances lc
        function void encode_statement(item_t it);
            logic [31:0]  v;
            logic [31:0]  off;
            logic [2:0]   f3;
            logic [6:0]   opc;
            logic [6:0]   f7;
            logic         emit;
            placed_word_t pw;
            emit = 1'b1;
            pw.addr = lc;
            pw.word = '0;
            if (it.action <= ACT_AND) begin
                case (it.action)
                    ACT_SLL:          f3 = 3'd1;
                    ACT_SLT:          f3 = 3'd2;
                    ACT_SLTU:         f3 = 3'd3;
                    ACT_XOR:          f3 = 3'd4;
                    ACT_SRL, ACT_SRA: f3 = 3'd5;
                    ACT_OR:           f3 = 3'd6;
                    ACT_AND:          f3 = 3'd7;
                    default:          f3 = 3'd0;
                endcase
                f7 = (it.action == ACT_SUB || it.action == ACT_SRA) ? FUNCT7_ALT : 7'd0;
                pw.word = {f7, it.src2_reg, it.src1_reg, f3, it.dest_reg, OPC_R};
            end
            else if (it.action <= ACT_ANDI) begin
                v = it.use_label ? it.label_address : it.immediate;
                opc = (it.action <= ACT_ECALL) ? OPC_JALR : OPC_I;
                case (it.action)
                    ACT_ECALL, ACT_ANDI:  f3 = 3'd7;
                    ACT_SLTI:             f3 = 3'd2;
                    ACT_SLTIU:            f3 = 3'd3;
                    ACT_SLLI:             f3 = 3'd1;
                    ACT_SRLI, ACT_SRAI:   f3 = 3'd5;
                    ACT_XORI:             f3 = 3'd4;
                    ACT_ORI:              f3 = 3'd6;
                    default:              f3 = 3'd0;
                endcase
                // shift amount keeps 5 bits, srai marks bit 30
                if (it.action >= ACT_SLLI && it.action <= ACT_SRAI) begin
                    v = {27'd0, v[4:0]};
                    if (it.action == ACT_SRAI)
                        v[11:5] = FUNCT7_ALT;
                end
                pw.word = {v[11:0], it.src1_reg, f3, it.dest_reg, opc};
            end
            else if (it.action <= ACT_LHU) begin
                case (it.action)
                    ACT_LH:  f3 = 3'd1;
                    ACT_LW:  f3 = 3'd2;
                    ACT_LBU: f3 = 3'd4;
                    ACT_LHU: f3 = 3'd5;
                    default: f3 = 3'd0;
                endcase
                pw.word = {it.immediate[11:0], it.src1_reg, f3, it.dest_reg, OPC_LOAD};
            end
            else if (it.action <= ACT_SW) begin
                f3 = 3'(it.action - ACT_SB);
                pw.word = {it.immediate[11:5], it.dest_reg, it.src1_reg, f3,
                           it.immediate[4:0], OPC_STORE};
            end
            else if (it.action <= ACT_BGEU) begin
                case (it.action)
                    ACT_BNE:  f3 = 3'd1;
                    ACT_BLT:  f3 = 3'd4;
                    ACT_BGE:  f3 = 3'd5;
                    ACT_BLTU: f3 = 3'd6;
                    ACT_BGEU: f3 = 3'd7;
                    default:  f3 = 3'd0;
                endcase
                // branches are always lc-relative, the label flag is ignored
                off = it.label_address - lc;
                pw.word = {off[12], off[10:5], it.src2_reg, it.src1_reg, f3,
                           off[4:1], off[11], OPC_BRANCH};
            end
            else if (it.action <= ACT_AUIPC) begin
                opc = (it.action == ACT_LUI) ? OPC_LUI : OPC_AUIPC;
                pw.word = {it.immediate[19:0], it.dest_reg, opc};
            end
            else if (it.action == ACT_JAL) begin
                off = it.use_label ? (it.label_address - lc) : it.immediate;
                pw.word = {off[20], off[10:1], off[11], off[19:12], it.dest_reg, OPC_JAL};
            end
            else if (it.action == ACT_FLW) begin
                pw.word = {it.immediate[11:0], it.src1_reg, FUNCT3_WORD, it.dest_reg, OPC_FLW};
            end
            else if (it.action == ACT_FSW) begin
                pw.word = {it.immediate[11:5], it.dest_reg, it.src1_reg, FUNCT3_WORD,
                           it.immediate[4:0], OPC_FSW};
            end
            else if (it.action == ACT_FADD_S) begin
                pw.word = {7'd0, it.src2_reg, it.src1_reg, FUNCT3_FADD, it.dest_reg, OPC_FOP};
            end
            else if (it.action == ACT_NOP) begin
                pw.word = '0;
            end
            else if (it.action == ACT_HALT) begin
                pw.word = WORD_HALT;
            end
            else if (it.action == ACT_DATA) begin
                emit = 1'b0;
                lc = lc + {16'd0, it.byte_count};
            end
            else begin
                emit = 1'b0;
            end
            if (emit) begin
                placed_words.push_back(pw);
                lc = lc + WORD_STEP;
            end
        endfunction

        function void check_word(logic [31:0] word, logic [31:0] addr);
            placed_word_t pw;
            if (placed_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: unexpected word %h at %h", $realtime, word, addr);
                return;
            end
            pw = placed_words.pop_front();
            words_checked++;
            if (word !== pw.word || addr !== pw.addr) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: word %h at %h, expected word %h at %h",
                             $realtime, word, addr, pw.word, pw.addr);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [5:0]         action;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
    logic [31:0]        label_address;
    logic               use_label;
    logic [15:0]        byte_count;
    logic               out_valid;
    logic               out_ready;
    logic [31:0]        machine_word;
    logic [31:0]        word_address;

    encoder_shadow shadow = new();
    bit            no_idle = 1'b0;
    int            idle_cycles = 0;
    int            statements_sent = 0;
    int            data_skips = 0;
    int            undefined_sent = 0;

    rv32_instruction_encoder uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .dest_reg      (dest_reg),
        .src1_reg      (src1_reg),
        .src2_reg      (src2_reg),
        .immediate     (immediate),
        .label_address (label_address),
        .use_label     (use_label),
        .byte_count    (byte_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .machine_word  (machine_word),
        .word_address  (word_address)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: nothing moved for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // caller stands at a rising edge; returns at the edge that took the word
    task automatic send_statement(input item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action        <= it.action;
        dest_reg      <= it.dest_reg;
        src1_reg      <= it.src1_reg;
        src2_reg      <= it.src2_reg;
        immediate     <= it.immediate;
        label_address <= it.label_address;
        use_label     <= it.use_label;
        byte_count    <= it.byte_count;
        in_valid      <= 1'b1;
        do @(posedge clk); while (!in_ready);
        shadow.encode_statement(it);
        statements_sent++;
        if (it.action == ACT_DATA)
            data_skips++;
        else if (it.action > ACT_DATA)
            undefined_sent++;
    endtask

    task automatic send_fields(input action_t act, input logic [4:0] rd, input logic [4:0] rs1,
                               input logic [4:0] rs2, input logic [31:0] imm,
                               input logic [31:0] lab, input logic ul, input logic [15:0] bytes);
        item_t it;
        it.action = act;
        it.dest_reg = rd;
        it.src1_reg = rs1;
        it.src2_reg = rs2;
        it.immediate = imm;
        it.label_address = lab;
        it.use_label = ul;
        it.byte_count = bytes;
        send_statement(it);
    endtask

    function automatic item_t random_statement();
        item_t it;
        int    pick;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            it.action = action_t'($urandom_range(ACT_ADD, ACT_HALT));
        else if (pick < 92)
            it.action = ACT_DATA;
        else
            it.action = action_t'($urandom_range(ACT_DATA + 1, ACT_UNDEF_LAST));
        it.dest_reg = 5'($urandom);
        it.src1_reg = 5'($urandom);
        it.src2_reg = 5'($urandom);
        it.use_label = 1'($urandom);
        case ($urandom_range(0, 5))
            0, 1:    it.immediate = $urandom;
            2:       it.immediate = 32'($urandom_range(0, 4095)) - 32'd2048;
            3:       it.immediate = ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4:       it.immediate = 32'($urandom_range(0, 31));
            default: it.immediate = 32'($urandom_range(0, 32'hF_FFFF));
        endcase
        // near targets give realistic branch offsets, far ones exercise wrap
        case ($urandom_range(0, 3))
            0:       it.label_address = $urandom;
            1:       it.label_address = shadow.lc + 32'($urandom_range(0, 8190)) - 32'd4096;
            2:       it.label_address = shadow.lc + 32'($urandom_range(0, 32'h1F_FFFE))
                                        - 32'h10_0000;
            default: it.label_address = shadow.lc + 32'($urandom_range(0, 64)) - 32'd32;
        endcase
        if ($urandom_range(0, 9) == 0)
            it.byte_count = 16'($urandom);
        else
            it.byte_count = 16'($urandom_range(0, 64));
        return it;
    endfunction

    initial
    begin : receiver
        int stall;
        int taken;
        out_ready = 1'b0;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 11);
            // long hold-off so the pipe fills and in_ready drops
            if (taken == HOLD_AT_WORD)
                stall = HOLD_OFF;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            shadow.check_word(machine_word, word_address);
            taken++;
        end
    end

    initial
    begin : stimulus
        item_t it;
        int    counted;
        int    drain;
        rst_n <= 1'b0;
        in_valid = 1'b0;
        action = ACT_NOP;
        dest_reg = '0;
        src1_reg = '0;
        src2_reg = '0;
        immediate = '0;
        label_address = '0;
        use_label = 1'b0;
        byte_count = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fields(ACT_ADD, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_SRA, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send_fields(ACT_SUB, 5'd31, 5'd0, 5'd31, 32'd0, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_ADDI, 5'd1, 5'd2, 5'd3, 32'h7FFF_FFFF, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_ADDI, 5'd31, 5'd31, 5'd0, 32'h8000_0000, 32'd0, 1'b0, 16'd0);
        // i-type label is taken as an absolute value
        send_fields(ACT_JALR, 5'd1, 5'd5, 5'd0, 32'd0, 32'hFFFF_FFFF, 1'b1, 16'd0);
        send_fields(ACT_ECALL, 5'd5, 5'd7, 5'd0, 32'h0000_0ABC, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_SLLI, 5'd3, 5'd4, 5'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_SRAI, 5'd3, 5'd4, 5'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_SRLI, 5'd6, 5'd6, 5'd0, 32'd0, 32'h0001_2345, 1'b1, 16'd0);
        // loads, stores, flw/fsw, lui and auipc ignore the label flag
        send_fields(ACT_LW, 5'd8, 5'd9, 5'd0, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 16'd0);
        send_fields(ACT_SB, 5'd31, 5'd1, 5'd0, 32'hFFFF_F7E0, 32'd0, 1'b1, 16'd0);
        send_fields(ACT_FSW, 5'd2, 5'd3, 5'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_FLW, 5'd4, 5'd5, 5'd0, 32'h0000_0800, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_LUI, 5'd31, 5'd0, 5'd0, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b1, 16'd0);
        send_fields(ACT_AUIPC, 5'd0, 5'd0, 5'd0, 32'h8000_0000, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_BEQ, 5'd0, 5'd1, 5'd2, 32'd0, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_BGEU, 5'd0, 5'd31, 5'd31, 32'd0, 32'hFFFF_FFFF, 1'b1, 16'd0);
        send_fields(ACT_JAL, 5'd1, 5'd0, 5'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_JAL, 5'd31, 5'd0, 5'd0, 32'd0, 32'h0010_0000, 1'b1, 16'd0);
        send_fields(ACT_FADD_S, 5'd31, 5'd31, 5'd31, 32'd0, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_NOP, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_HALT, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 1'b0, 16'd0);
        send_fields(ACT_DATA, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 1'b0, 16'hFFFF);
        send_fields(ACT_DATA, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0, 1'b0, 16'd3);
        send_fields(ACT_UNDEF_LAST, 5'd1, 5'd1, 5'd1, 32'd1, 32'd1, 1'b1, 16'd8);
        send_fields(ACT_ADD, 5'd1, 5'd2, 5'd3, 32'd0, 32'd0, 1'b0, 16'd0);

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            // every fourth stretch runs back to back on both sides
            no_idle = ((counted / 100) % 4) == 2;
            it = random_statement();
            send_statement(it);
            if (it.action <= ACT_DATA)
                counted++;
        end
        in_valid <= 1'b0;
        no_idle = 1'b0;

        while (shadow.placed_words.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < DRAIN_CYCLES) begin
            @(posedge clk);
            drain++;
        end

        $display("sent %0d statements (%0d data skips, %0d undefined), checked %0d words",
                 statements_sent, data_skips, undefined_sent, shadow.words_checked);
        $display("all mnemonics, label and immediate forms, offset wrap and a %0d-cycle stall",
                 HOLD_OFF);
        if (shadow.mismatches == 0 && shadow.placed_words.size() == 0) begin
            $display("SUCCESS");
        end
        else begin
            $display("%0d mismatches, %0d words missing", shadow.mismatches,
                     shadow.placed_words.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/rv32e_pkg.sv
src/rv32e_encode.sv
src/rv32_instruction_encoder.sv
src/rv32e_checker.sv
bench/rv32_instruction_encoder_tb.sv
